// File: sv/sssd_pkg.sv
package sssd_pkg;

    // Operation codes carried by the input transfer
    typedef enum logic [2:0] {
        OP_TICK    = 3'd0,
        OP_SET     = 3'd1,
        OP_ON      = 3'd2,
        OP_OFF     = 3'd3,
        OP_TOGGLE  = 3'd4
    } opcode_t;

    // One input item
    typedef struct packed {
        logic [2:0] opcode;
        logic [7:0] value;
    } item_t;

    // One result item
    typedef struct packed {
        logic [7:0] segment_lines;
        logic [3:0] digit_lines;
        logic [7:0] shown_value;
    } result_t;

    localparam logic [7:0] MAX_VALUE     = 8'd199;
    localparam logic [7:0] HUNDRED       = 8'd100;
    localparam logic [3:0] LAST_DIGIT_ST = 4'd13;
    localparam logic [3:0] FIRST_TENS_ST = 4'd7;
    localparam logic [3:0] HUND_LO_ST    = 4'd14;

    localparam logic [7:0] SEG_BLANK     = 8'hff;
    localparam logic [3:0] DIG_RESET     = 4'b1100;
    localparam logic [3:0] DIG_CATH_MASK = 4'b1100;
    localparam logic [3:0] DIG_ONES      = 4'b1101;
    localparam logic [3:0] DIG_TENS      = 4'b1110;
    localparam logic [3:0] DIG_HUND_LO   = 4'b1010;
    localparam logic [3:0] DIG_HUND_HI   = 4'b0110;

    // Segment pattern for one decimal digit, bit0 a to bit6 g; codes above 9 show 9
    function automatic logic [7:0] seg_pattern(input logic [3:0] digit);
        logic [7:0] pat;
        case (digit)
            4'd0:    pat = 8'h3f;
            4'd1:    pat = 8'h06;
            4'd2:    pat = 8'h5b;
            4'd3:    pat = 8'h4f;
            4'd4:    pat = 8'h66;
            4'd5:    pat = 8'h6d;
            4'd6:    pat = 8'h7d;
            4'd7:    pat = 8'h07;
            4'd8:    pat = 8'h7f;
            default: pat = 8'h6f;
        endcase
        return pat;
    endfunction

endpackage

// File: sv/seven_segment_scan_driver.sv
// Channel | Direction | Handshake          | Payload
// s_      | input     | s_valid / s_ready  | s_opcode[2:0], s_value[7:0]
// m_      | output    | m_valid / m_ready  | m_segment_lines[7:0], m_digit_lines[3:0],
//         |           |                    | m_shown_value[7:0]
//
// One item per cycle sustained while m_ready stays high.
// Each item is applied from the input register straight into the result register.
// Synchronous active-low reset blanks the segments, sets both hundreds cathodes high
// and turns the display off. A stalled result holds the item in the input register,
// and s_ready drops only while both registers are full.
module seven_segment_scan_driver (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [2:0] s_opcode,
    input  logic [7:0] s_value,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [7:0] m_segment_lines,
    output logic [3:0] m_digit_lines,
    output logic [7:0] m_shown_value
);
    import sssd_pkg::*;

    item_t   s_item;
    item_t   item;
    logic    item_valid;
    logic    can_load;
    logic    apply;
    result_t result;
    result_t m_result;

    assign s_item.opcode = s_opcode;
    assign s_item.value  = s_value;

    // Move the held item forward when the result slot is free
    assign apply = item_valid && can_load;

    sssd_in_stage u_in (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_item     (s_item),
        .item_valid (item_valid),
        .item       (item),
        .item_take  (apply)
    );

    sssd_core u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .apply   (apply),
        .item    (item),
        .result  (result)
    );

    sssd_out_stage u_out (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .load     (apply),
        .can_load (can_load),
        .result   (result),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_result (m_result)
    );

    assign m_segment_lines = m_result.segment_lines;
    assign m_digit_lines   = m_result.digit_lines;
    assign m_shown_value   = m_result.shown_value;

endmodule

// File: sv/sssd_in_stage.sv
module sssd_in_stage (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_valid,
    output logic           s_ready,
    input  sssd_pkg::item_t s_item,
    output logic           item_valid,
    output sssd_pkg::item_t item,
    input  logic           item_take
);
    import sssd_pkg::*;

    logic  valid_reg, valid_next;
    item_t item_reg;

    // Accept a new transfer whenever the held item is empty or leaves this cycle
    assign s_ready    = !valid_reg || item_take;
    assign valid_next = (s_valid && s_ready) ? 1'b1 : (item_take ? 1'b0 : valid_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    // Capture payload on transfer
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            item_reg <= s_item;
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

// File: sv/sssd_core.sv
module sssd_core (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             apply,
    input  sssd_pkg::item_t  item,
    output sssd_pkg::result_t result
);
    import sssd_pkg::*;

    logic [3:0] ones_reg, ones_next;
    logic [3:0] tens_reg, tens_next;
    logic       hund_reg, hund_next;
    logic [7:0] loaded_reg, loaded_next;
    logic [3:0] scan_reg, scan_next;
    logic       enabled_reg, enabled_next;
    logic [7:0] segment_reg, segment_next;
    logic [3:0] digit_reg, digit_next;

    // Value split
    logic [7:0]  sat_val;
    logic        is_hund;
    logic [6:0]  rem_val;
    logic [14:0] tens_prod;
    logic [3:0]  tens_val;
    logic [6:0]  tens_x10;
    logic [3:0]  ones_val;

    // Scan step
    logic       step_tens;
    logic [2:0] bit_idx;
    logic [3:0] step_digit;
    logic [7:0] step_mask;
    logic [7:0] tick_seg;
    logic [3:0] tick_dig;

    // Saturate and split into hundreds flag, tens and ones (reciprocal multiply by 205/2048)
    always_comb begin
        sat_val   = (item.value > MAX_VALUE) ? MAX_VALUE : item.value;
        is_hund   = (sat_val >= HUNDRED);
        rem_val   = is_hund ? 7'(sat_val - HUNDRED) : sat_val[6:0];
        tens_prod = 15'(rem_val) * 15'd205;
        tens_val  = tens_prod[14:11];
        tens_x10  = 7'({tens_val, 3'b000}) + 7'({tens_val, 1'b0});
        ones_val  = 4'(rem_val - tens_x10);
    end

    // Lines for the current scan step
    always_comb begin
        step_tens  = (scan_reg >= FIRST_TENS_ST);
        bit_idx    = step_tens ? 3'(scan_reg - FIRST_TENS_ST) : scan_reg[2:0];
        step_digit = step_tens ? tens_reg : ones_reg;
        step_mask  = 8'd1 << bit_idx;
        if (scan_reg <= LAST_DIGIT_ST) begin
            tick_seg = ~(seg_pattern(step_digit) & step_mask);
            tick_dig = (digit_reg & DIG_CATH_MASK) | (step_tens ? DIG_TENS : DIG_ONES);
        end else begin
            tick_seg = SEG_BLANK;
            if (hund_reg) begin
                tick_dig = (scan_reg == HUND_LO_ST) ? DIG_HUND_LO : DIG_HUND_HI;
            end else begin
                tick_dig = (digit_reg & DIG_CATH_MASK)
                         | ((scan_reg == HUND_LO_ST) ? DIG_HUND_LO : DIG_HUND_HI);
            end
        end
    end

    // Next state per opcode
    always_comb begin
        ones_next    = ones_reg;
        tens_next    = tens_reg;
        hund_next    = hund_reg;
        loaded_next  = loaded_reg;
        scan_next    = scan_reg;
        enabled_next = enabled_reg;
        segment_next = segment_reg;
        digit_next   = digit_reg;
        if (apply) begin
            case (opcode_t'(item.opcode))
                OP_TICK: begin
                    if (enabled_reg) begin
                        segment_next = tick_seg;
                        digit_next   = tick_dig;
                        scan_next    = scan_reg + 4'd1;
                    end
                end
                OP_SET: begin
                    ones_next   = ones_val;
                    tens_next   = tens_val;
                    hund_next   = is_hund;
                    loaded_next = sat_val;
                end
                OP_ON: begin
                    enabled_next = 1'b1;
                end
                OP_OFF: begin
                    digit_next   = digit_reg & DIG_CATH_MASK;
                    segment_next = SEG_BLANK;
                    scan_next    = '0;
                    enabled_next = 1'b0;
                end
                OP_TOGGLE: begin
                    if (enabled_reg) begin
                        digit_next   = digit_reg & DIG_CATH_MASK;
                        segment_next = SEG_BLANK;
                        scan_next    = '0;
                        enabled_next = 1'b0;
                    end else begin
                        enabled_next = 1'b1;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ones_reg    <= '0;
            tens_reg    <= '0;
            hund_reg    <= 1'b0;
            loaded_reg  <= '0;
            scan_reg    <= '0;
            enabled_reg <= 1'b0;
            segment_reg <= SEG_BLANK;
            digit_reg   <= DIG_RESET;
        end else begin
            ones_reg    <= ones_next;
            tens_reg    <= tens_next;
            hund_reg    <= hund_next;
            loaded_reg  <= loaded_next;
            scan_reg    <= scan_next;
            enabled_reg <= enabled_next;
            segment_reg <= segment_next;
            digit_reg   <= digit_next;
        end
    end

    // Result reflects the state after this item
    assign result.segment_lines = segment_next;
    assign result.digit_lines   = digit_next;
    assign result.shown_value   = loaded_next;

endmodule

// File: sv/sssd_out_stage.sv
module sssd_out_stage (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              load,
    output logic              can_load,
    input  sssd_pkg::result_t result,
    output logic              m_valid,
    input  logic              m_ready,
    output sssd_pkg::result_t m_result
);
    import sssd_pkg::*;

    logic    valid_reg, valid_next;
    result_t result_reg;

    // Slot frees up when empty or when the held result transfers
    assign can_load   = !valid_reg || m_ready;
    assign valid_next = load ? 1'b1 : (m_ready ? 1'b0 : valid_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    // Hold result until transfer
    always_ff @(posedge aclk) begin
        if (load) begin
            result_reg <= result;
        end
    end

    assign m_valid  = valid_reg;
    assign m_result = result_reg;

endmodule
